// ===== hdl/ledfb_pkg.sv =====
package ledfb_pkg;

    localparam int NUM_LEDS = 64;
    localparam int ADDR_W   = (NUM_LEDS > 2) ? $clog2(NUM_LEDS) : 1;
    localparam int SUM_W    = ADDR_W + 1;
    localparam int MEM_AW   = ADDR_W + 1;
    localparam int MEM_DEPTH = 2 * NUM_LEDS;

    localparam int ACTION_W  = 4;
    localparam int INDEX_W   = 6;
    localparam int CHAN_W    = 8;
    localparam int PIXEL_W   = 3 * CHAN_W;
    localparam int PCT_W     = 7;
    localparam int AMOUNT_W  = 8;
    localparam int IDX_WIDE_W = INDEX_W + ADDR_W;
    localparam int AMT_WIDE_W = AMOUNT_W + SUM_W;

    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 32;

    localparam logic [PCT_W-1:0] PCT_FULL = PCT_W'(100);
    localparam logic [CHAN_W-1:0] CHAN_MAX = {CHAN_W{1'b1}};

    localparam int PROD_W      = CHAN_W + PCT_W;
    localparam int RECIP_W     = 16;
    localparam int SCALE_SHIFT = 22;
    localparam logic [RECIP_W-1:0] SCALE_RECIP = RECIP_W'(((1 << SCALE_SHIFT) / 100) + 1);
    localparam int QPROD_W     = PROD_W + RECIP_W;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NUM_LEDS - 1);
    localparam logic [SUM_W-1:0]  N_SUM     = SUM_W'(NUM_LEDS);

    typedef enum logic [ACTION_W-1:0] {
        ACT_WRITE      = 4'd0,
        ACT_READ       = 4'd1,
        ACT_ADD        = 4'd2,
        ACT_SCALE_ONE  = 4'd3,
        ACT_SCALE_ALL  = 4'd4,
        ACT_INVERT_ONE = 4'd5,
        ACT_INVERT_ALL = 4'd6,
        ACT_SHIFT_UP   = 4'd7,
        ACT_SHIFT_DOWN = 4'd8,
        ACT_ROT_DOWN   = 4'd9,
        ACT_ROT_UP     = 4'd10
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_ISSUE,
        ST_DRAIN,
        ST_READ,
        ST_LOAD
    } state_t;

endpackage

// ===== hdl/rgb_led_frame_buffer_engine_core.sv =====
// Channel   Dir  Handshake            tdata fields (low bit up)
// s_        in   s_tvalid / s_tready  action, led_index, red_in, green_in, blue_in,
//                                     percent, shift_amount (49 bits in 56)
// m_        out  m_tvalid / m_tready  red_out, green_out, blue_out, ignored (25 in 32)
//
// Whole-strip commands run one pixel a cycle through the single
// memory read port and the shared pixel unit, into the other bank of a two-bank store.
// Per-pixel commands issue and drain before the read; read and other commands skip both.
// Reset clears the entry valid bits at once, so the store reads black with no sweep.
// A waiting result holds in the output register; the next item is still accepted and
// its result waits until the output register frees.
module rgb_led_frame_buffer_engine_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // action, led_index, red_in, green_in, blue_in, percent, shift_amount
    input  logic [ledfb_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // red_out, green_out, blue_out, ignored
    output logic [ledfb_pkg::M_TDATA_W-1:0] m_tdata
);

    ledfb_pkg::state_t state_reg, state_next;

    logic [ledfb_pkg::ACTION_W-1:0] cmd_action_reg;
    logic [ledfb_pkg::INDEX_W-1:0]  cmd_index_reg;
    logic [ledfb_pkg::CHAN_W-1:0]   cmd_red_reg, cmd_green_reg, cmd_blue_reg;
    logic [ledfb_pkg::PCT_W-1:0]    cmd_pct_reg;
    logic [ledfb_pkg::AMOUNT_W-1:0] cmd_amount_reg;

    logic [ledfb_pkg::ADDR_W-1:0] cnt_reg, cnt_next;
    logic                         bank_reg, bank_next;

    logic [ledfb_pkg::PIXEL_W-1:0] mem [ledfb_pkg::MEM_DEPTH];
    logic [ledfb_pkg::MEM_DEPTH-1:0] vld_reg;
    logic [ledfb_pkg::PIXEL_W-1:0] rd_data_reg;
    logic                          rd_vld_reg;

    logic                          rd_en;
    logic [ledfb_pkg::MEM_AW-1:0]  rd_addr;
    logic                          issue_en;
    logic                          load_out;

    logic                          s1_valid_reg, s1_black_reg, s1_wbank_reg;
    logic [ledfb_pkg::ADDR_W-1:0]  s1_waddr_reg;
    logic                          s2_valid_reg, s2_wbank_reg;
    logic [ledfb_pkg::ADDR_W-1:0]  s2_waddr_reg;
    logic [ledfb_pkg::PIXEL_W-1:0] s2_pix_reg;
    logic [ledfb_pkg::PROD_W-1:0]  s2_prod_r_reg, s2_prod_g_reg, s2_prod_b_reg;

    logic                          m_tvalid_reg;
    logic [ledfb_pkg::PIXEL_W-1:0] out_pix_reg;
    logic                          out_ignored_reg;

    logic [ledfb_pkg::IDX_WIDE_W-1:0] idx_wide;
    logic [ledfb_pkg::ADDR_W-1:0]     idx_addr;
    logic                             idx_valid;
    logic [ledfb_pkg::AMT_WIDE_W-1:0] amt_wide;
    logic [ledfb_pkg::SUM_W-1:0]      k_sum, i_sum;
    logic [ledfb_pkg::SUM_W-1:0]      diff_up, sum_dn, wrap_dn, sum_ru, wrap_ru;
    logic                             is_move, ignored, whole_op, pixel_op, scale_op;
    logic [ledfb_pkg::PCT_W-1:0]      pct_clamped;

    logic [ledfb_pkg::ADDR_W-1:0]  src_addr, issue_waddr;
    logic                          src_black, issue_wbank;

    logic [ledfb_pkg::PIXEL_W-1:0] s1_pix, s1_result;
    logic [ledfb_pkg::CHAN_W:0]    add_r, add_g, add_b;
    logic [ledfb_pkg::QPROD_W-1:0] q_r, q_g, q_b;
    logic [ledfb_pkg::PIXEL_W-1:0] wr_data;

    assign idx_wide  = {{ledfb_pkg::ADDR_W{1'b0}}, cmd_index_reg};
    assign idx_addr  = idx_wide[ledfb_pkg::ADDR_W-1:0];
    assign idx_valid = idx_wide < ledfb_pkg::IDX_WIDE_W'(ledfb_pkg::NUM_LEDS);
    assign amt_wide  = {{ledfb_pkg::SUM_W{1'b0}}, cmd_amount_reg};
    assign k_sum     = amt_wide[ledfb_pkg::SUM_W-1:0];
    assign i_sum     = {1'b0, cnt_reg};

    assign pct_clamped = (cmd_pct_reg > ledfb_pkg::PCT_FULL) ? ledfb_pkg::PCT_FULL
                                                             : cmd_pct_reg;

    always_comb begin
        is_move  = 1'b0;
        whole_op = 1'b0;
        pixel_op = 1'b0;
        scale_op = 1'b0;
        unique case (cmd_action_reg) inside
            ledfb_pkg::ACT_WRITE, ledfb_pkg::ACT_ADD, ledfb_pkg::ACT_INVERT_ONE: begin
                pixel_op = idx_valid;
            end
            ledfb_pkg::ACT_SCALE_ONE: begin
                pixel_op = idx_valid;
                scale_op = 1'b1;
            end
            ledfb_pkg::ACT_SCALE_ALL: begin
                whole_op = 1'b1;
                scale_op = 1'b1;
            end
            ledfb_pkg::ACT_INVERT_ALL: begin
                whole_op = 1'b1;
            end
            ledfb_pkg::ACT_SHIFT_UP, ledfb_pkg::ACT_SHIFT_DOWN,
            ledfb_pkg::ACT_ROT_DOWN, ledfb_pkg::ACT_ROT_UP: begin
                is_move = 1'b1;
            end
            default: begin
            end
        endcase
        ignored = is_move && ((cmd_amount_reg == '0) ||
                  (amt_wide >= ledfb_pkg::AMT_WIDE_W'(ledfb_pkg::NUM_LEDS)));
        if (is_move && !ignored) begin
            whole_op = 1'b1;
        end
    end

    assign diff_up = i_sum - k_sum;
    assign sum_dn  = i_sum + k_sum;
    assign wrap_dn = sum_dn - ledfb_pkg::N_SUM;
    assign sum_ru  = i_sum + (ledfb_pkg::N_SUM - k_sum);
    assign wrap_ru = sum_ru - ledfb_pkg::N_SUM;

    always_comb begin
        src_addr  = cnt_reg;
        src_black = 1'b0;
        case (cmd_action_reg)
            ledfb_pkg::ACT_SHIFT_UP: begin
                src_addr  = diff_up[ledfb_pkg::ADDR_W-1:0];
                src_black = i_sum < k_sum;
            end
            ledfb_pkg::ACT_SHIFT_DOWN: begin
                src_addr  = sum_dn[ledfb_pkg::ADDR_W-1:0];
                src_black = sum_dn >= ledfb_pkg::N_SUM;
            end
            ledfb_pkg::ACT_ROT_DOWN: begin
                src_addr = (sum_dn >= ledfb_pkg::N_SUM) ? wrap_dn[ledfb_pkg::ADDR_W-1:0]
                                                        : sum_dn[ledfb_pkg::ADDR_W-1:0];
            end
            ledfb_pkg::ACT_ROT_UP: begin
                src_addr = (sum_ru >= ledfb_pkg::N_SUM) ? wrap_ru[ledfb_pkg::ADDR_W-1:0]
                                                        : sum_ru[ledfb_pkg::ADDR_W-1:0];
            end
            default: begin
            end
        endcase
        if (!whole_op) begin
            src_addr  = idx_addr;
            src_black = 1'b0;
        end
    end

    assign issue_waddr = whole_op ? cnt_reg : idx_addr;
    assign issue_wbank = whole_op ? !bank_reg : bank_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ledfb_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ledfb_pkg::ST_DECODE;
                end
            end
            ledfb_pkg::ST_DECODE: begin
                if (whole_op || pixel_op) begin
                    state_next = ledfb_pkg::ST_ISSUE;
                end else begin
                    state_next = ledfb_pkg::ST_READ;
                end
            end
            ledfb_pkg::ST_ISSUE: begin
                if (!whole_op || (cnt_reg == ledfb_pkg::LAST_ADDR)) begin
                    state_next = ledfb_pkg::ST_DRAIN;
                end
            end
            ledfb_pkg::ST_DRAIN: begin
                if (!s1_valid_reg && !s2_valid_reg) begin
                    state_next = ledfb_pkg::ST_READ;
                end
            end
            ledfb_pkg::ST_READ: begin
                state_next = ledfb_pkg::ST_LOAD;
            end
            ledfb_pkg::ST_LOAD: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = ledfb_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ledfb_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready  = 1'b0;
        issue_en  = 1'b0;
        rd_en     = 1'b0;
        rd_addr   = {bank_reg, idx_addr};
        load_out  = 1'b0;
        cnt_next  = cnt_reg;
        bank_next = bank_reg;
        unique case (state_reg)
            ledfb_pkg::ST_IDLE: begin
                s_tready = 1'b1;
            end
            ledfb_pkg::ST_DECODE: begin
                cnt_next = '0;
            end
            ledfb_pkg::ST_ISSUE: begin
                issue_en = 1'b1;
                rd_en    = 1'b1;
                rd_addr  = {bank_reg, src_addr};
                cnt_next = cnt_reg + ledfb_pkg::ADDR_W'(1);
            end
            ledfb_pkg::ST_DRAIN: begin
                if (!s1_valid_reg && !s2_valid_reg && whole_op) begin
                    bank_next = !bank_reg;
                end
            end
            ledfb_pkg::ST_READ: begin
                rd_en = 1'b1;
            end
            ledfb_pkg::ST_LOAD: begin
                load_out = !m_tvalid_reg || m_tready;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ledfb_pkg::ST_IDLE;
            cnt_reg      <= '0;
            bank_reg     <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            bank_reg     <= bank_next;
            s1_valid_reg <= issue_en;
            s2_valid_reg <= s1_valid_reg;
            if (load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            cmd_action_reg <= s_tdata[3:0];
            cmd_index_reg  <= s_tdata[9:4];
            cmd_red_reg    <= s_tdata[17:10];
            cmd_green_reg  <= s_tdata[25:18];
            cmd_blue_reg   <= s_tdata[33:26];
            cmd_pct_reg    <= s_tdata[40:34];
            cmd_amount_reg <= s_tdata[48:41];
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_valid_reg) begin
            mem[{s2_wbank_reg, s2_waddr_reg}] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (s2_valid_reg) begin
                vld_reg[{s2_wbank_reg, s2_waddr_reg}] <= 1'b1;
            end
            if (rd_en) begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (issue_en) begin
            s1_waddr_reg <= issue_waddr;
            s1_wbank_reg <= issue_wbank;
            s1_black_reg <= src_black;
        end
    end

    assign s1_pix = (s1_black_reg || !rd_vld_reg) ? '0 : rd_data_reg;
    assign add_r  = {1'b0, s1_pix[23:16]} + {1'b0, cmd_red_reg};
    assign add_g  = {1'b0, s1_pix[15:8]}  + {1'b0, cmd_green_reg};
    assign add_b  = {1'b0, s1_pix[7:0]}   + {1'b0, cmd_blue_reg};

    always_comb begin
        s1_result = s1_pix;
        case (cmd_action_reg) inside
            ledfb_pkg::ACT_WRITE: begin
                s1_result = {cmd_red_reg, cmd_green_reg, cmd_blue_reg};
            end
            ledfb_pkg::ACT_ADD: begin
                s1_result = {add_r[8] ? ledfb_pkg::CHAN_MAX : add_r[7:0],
                             add_g[8] ? ledfb_pkg::CHAN_MAX : add_g[7:0],
                             add_b[8] ? ledfb_pkg::CHAN_MAX : add_b[7:0]};
            end
            ledfb_pkg::ACT_INVERT_ONE, ledfb_pkg::ACT_INVERT_ALL: begin
                s1_result = ~s1_pix;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (s1_valid_reg) begin
            s2_waddr_reg  <= s1_waddr_reg;
            s2_wbank_reg  <= s1_wbank_reg;
            s2_pix_reg    <= s1_result;
            s2_prod_r_reg <= {{ledfb_pkg::PCT_W{1'b0}}, s1_pix[23:16]} *
                             {{ledfb_pkg::CHAN_W{1'b0}}, pct_clamped};
            s2_prod_g_reg <= {{ledfb_pkg::PCT_W{1'b0}}, s1_pix[15:8]} *
                             {{ledfb_pkg::CHAN_W{1'b0}}, pct_clamped};
            s2_prod_b_reg <= {{ledfb_pkg::PCT_W{1'b0}}, s1_pix[7:0]} *
                             {{ledfb_pkg::CHAN_W{1'b0}}, pct_clamped};
        end
    end

    assign q_r = {{ledfb_pkg::RECIP_W{1'b0}}, s2_prod_r_reg} *
                 {{ledfb_pkg::PROD_W{1'b0}}, ledfb_pkg::SCALE_RECIP};
    assign q_g = {{ledfb_pkg::RECIP_W{1'b0}}, s2_prod_g_reg} *
                 {{ledfb_pkg::PROD_W{1'b0}}, ledfb_pkg::SCALE_RECIP};
    assign q_b = {{ledfb_pkg::RECIP_W{1'b0}}, s2_prod_b_reg} *
                 {{ledfb_pkg::PROD_W{1'b0}}, ledfb_pkg::SCALE_RECIP};

    assign wr_data = scale_op
        ? {q_r[ledfb_pkg::SCALE_SHIFT+7:ledfb_pkg::SCALE_SHIFT],
           q_g[ledfb_pkg::SCALE_SHIFT+7:ledfb_pkg::SCALE_SHIFT],
           q_b[ledfb_pkg::SCALE_SHIFT+7:ledfb_pkg::SCALE_SHIFT]}
        : s2_pix_reg;

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_pix_reg     <= (idx_valid && rd_vld_reg) ? rd_data_reg : '0;
            out_ignored_reg <= ignored;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'b0, out_ignored_reg, out_pix_reg[7:0], out_pix_reg[15:8],
                       out_pix_reg[23:16]};

    a_ready_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (!s1_valid_reg && !s2_valid_reg))
        else $error("input ready while pixel pipeline busy");

    a_write_window: assert property (@(posedge aclk) disable iff (!aresetn)
        s2_valid_reg |-> (state_reg == ledfb_pkg::ST_ISSUE ||
                          state_reg == ledfb_pkg::ST_DRAIN))
        else $error("store write outside sweep");

    a_bank_flip: assert property (@(posedge aclk) disable iff (!aresetn)
        !$stable(bank_reg) |-> (state_reg == ledfb_pkg::ST_READ &&
                                $past(state_reg) == ledfb_pkg::ST_DRAIN))
        else $error("bank flipped outside end of sweep");

    a_load_done: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |=> (m_tvalid_reg && state_reg == ledfb_pkg::ST_IDLE))
        else $error("result load did not post item");

endmodule
